// ===== rtl/core/lei_pkg.sv =====
// Shared types and constants for the Lorenz Euler integrator.
// Request, response and position structs, state codes and register indexes.
// No dependencies.
package lei_pkg;

   localparam int PARTICLE_COUNT = 16;
   localparam int MAX_SUBSTEPS   = 64;

   localparam int IDX_W       = 4;
   localparam int ADDR_W      = $clog2(PARTICLE_COUNT);
   localparam int COORD_W     = 32;
   localparam int COEF_W      = 31;
   localparam int SUBSTEPS_W  = 7;
   localparam int FRAME_W     = 23;
   localparam int FRAME_MAX   = 4194304;
   localparam int FRAC_W      = 22;
   localparam int H_FRAC_W    = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 31;

   // step size is frame time in Q1.24 divided by the substep count
   localparam int DVD_W       = FRAME_W + 2;
   localparam int DIV_CNT_W   = $clog2(DVD_W);
   localparam int N_W         = $clog2(MAX_SUBSTEPS + 1);

   // shared multiplier: a takes a difference, a coordinate or a saturated rate, b a coordinate,
   // a coefficient or the step size
   localparam int MUL_A_W     = 39;
   localparam int MUL_B_W     = 32;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int RATE_W      = 46;
   localparam int SUM_W       = COORD_W + 9;

   localparam logic [COEF_W-1:0]     SIGMA_RESET    = COEF_W'(41943040);
   localparam logic [COEF_W-1:0]     RHO_RESET      = COEF_W'(117440512);
   localparam logic [COEF_W-1:0]     BETA_RESET     = COEF_W'(11184811);
   localparam logic [SUBSTEPS_W-1:0] SUBSTEPS_RESET = SUBSTEPS_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA    = 2'd0,
      CSR_RHO      = 2'd1,
      CSR_BETA     = 2'd2,
      CSR_SUBSTEPS = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ADVANCE = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIV,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_M7,
      ST_M8
   } state_type;

   typedef struct packed {
      logic                      command;
      logic [IDX_W-1:0]          particle;
      logic signed [COORD_W-1:0] load_x;
      logic signed [COORD_W-1:0] load_y;
      logic signed [COORD_W-1:0] load_z;
      logic [FRAME_W-1:0]        frame_dur;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          out_particle;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pos_type;

endpackage

// ===== rtl/core/lorenz_euler_integrator.sv =====
// Lorenz attractor particle integrator, forward Euler in Q10.22 fixed point.
// Depends on lei_pkg for the request, response and position types.
//
// A load request writes one particle's position and returns it as a single
// response. An advance request runs n forward Euler substeps (n = substeps
// register, clamped to 1..MAX_SUBSTEPS) and returns one point per substep,
// the final one flagged with last and written back to the table. An advance
// first runs the bit-serial divider that forms the step size, then each
// substep, paced by the single shared multiplier that forms all seven products
// of a substep in turn. One request is worked on at a time; requests naming a
// particle beyond the table give no response. Positions read as zero until
// loaded or advanced.
module lorenz_euler_integrator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lei_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lei_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [lei_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lei_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic signed [lei_pkg::RATE_W-1:0] RATE_HI =
      lei_pkg::RATE_W'((64'sd1 <<< (lei_pkg::MUL_A_W - 1)) - 64'sd1);
   localparam logic signed [lei_pkg::RATE_W-1:0] RATE_LO = -RATE_HI;

   function automatic logic signed [lei_pkg::MUL_A_W-1:0] sat_rate(
      input logic signed [lei_pkg::RATE_W-1:0] v);
      logic signed [lei_pkg::RATE_W-1:0] r;
      r = v;
      if (v > RATE_HI) r = RATE_HI;
      else if (v < RATE_LO) r = RATE_LO;
      return lei_pkg::MUL_A_W'(r);
   endfunction

   function automatic logic signed [lei_pkg::COORD_W-1:0] sat_coord(
      input logic signed [lei_pkg::SUM_W-1:0] v);
      logic signed [lei_pkg::SUM_W-1:0] hi;
      logic signed [lei_pkg::SUM_W-1:0] lo;
      hi = lei_pkg::SUM_W'($signed({1'b0, {(lei_pkg::COORD_W-1){1'b1}}}));
      lo = lei_pkg::SUM_W'($signed({1'b1, {(lei_pkg::COORD_W-1){1'b0}}}));
      if (v > hi) return lei_pkg::COORD_W'(hi);
      if (v < lo) return lei_pkg::COORD_W'(lo);
      return lei_pkg::COORD_W'(v);
   endfunction

   // configuration
   logic [lei_pkg::COEF_W-1:0]     sigma_ff, rho_ff, beta_ff;
   logic [lei_pkg::SUBSTEPS_W-1:0] substeps_ff;

   // sequencer and datapath
   lei_pkg::state_type                 state_ff, state_in;
   logic [lei_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [lei_pkg::N_W-1:0]            n_ff, n_in;
   logic [lei_pkg::N_W-1:0]            step_ff, step_in;
   logic [lei_pkg::N_W-1:0]            rem_ff, rem_in;
   logic [lei_pkg::DVD_W-1:0]          dvd_ff, dvd_in;
   logic [lei_pkg::DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic signed [lei_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [lei_pkg::COORD_W-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [lei_pkg::RATE_W-1:0]  rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic signed [lei_pkg::RATE_W-1:0]  tmp_ff, tmp_in;
   logic signed [lei_pkg::PROD_W-1:0]  prod_ff;
   logic signed [lei_pkg::MUL_A_W-1:0] mul_a;
   logic signed [lei_pkg::MUL_B_W-1:0] mul_b;
   logic                               rsp_valid_ff, rsp_valid_in;
   lei_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   // position table
   lei_pkg::pos_type                   pos_mem [lei_pkg::PARTICLE_COUNT];
   logic [lei_pkg::PARTICLE_COUNT-1:0] vld_ff;
   lei_pkg::pos_type                   rd_ff;
   logic                               rd_vld_ff;
   logic                               mem_we;
   logic [lei_pkg::ADDR_W-1:0]         mem_addr;
   lei_pkg::pos_type                   mem_wdata;

   logic                               req_accept;
   logic                               in_range;
   logic [lei_pkg::FRAME_W-1:0]        ft_sat;
   logic [lei_pkg::N_W:0]              rem_try;
   logic signed [lei_pkg::PROD_W-1:0]  prod_sh22, prod_sh24;
   logic signed [lei_pkg::SUM_W-1:0]   coord_sum;
   logic signed [lei_pkg::COORD_W-1:0] coord_new;
   logic signed [lei_pkg::COORD_W+1:0] rho_s, z_ext;
   logic signed [lei_pkg::COORD_W:0]   diff_yx;

   assign req_stall  = (state_ff != lei_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign in_range = ({1'b0, req_data.particle} <
                      (lei_pkg::IDX_W+1)'(lei_pkg::PARTICLE_COUNT));
   assign ft_sat   = (req_data.frame_dur > lei_pkg::FRAME_W'(lei_pkg::FRAME_MAX)) ?
                     lei_pkg::FRAME_W'(lei_pkg::FRAME_MAX) : req_data.frame_dur;
   assign rem_try  = {rem_ff, dvd_ff[lei_pkg::DVD_W-1]};

   assign prod_sh22 = prod_ff >>> lei_pkg::FRAC_W;
   assign prod_sh24 = prod_ff >>> lei_pkg::H_FRAC_W;
   assign diff_yx   = (lei_pkg::COORD_W+1)'(y_ff) - (lei_pkg::COORD_W+1)'(x_ff);
   assign rho_s     = $signed({2'b00, 1'b0, rho_ff});
   assign z_ext     = (lei_pkg::COORD_W+2)'(z_ff);

   // coordinate update for whichever axis the sequencer is finishing
   always_comb begin
      unique case (state_ff)
         lei_pkg::ST_M6: coord_sum = lei_pkg::SUM_W'(x_ff) + lei_pkg::SUM_W'(prod_sh24);
         lei_pkg::ST_M7: coord_sum = lei_pkg::SUM_W'(y_ff) + lei_pkg::SUM_W'(prod_sh24);
         default:        coord_sum = lei_pkg::SUM_W'(z_ff) + lei_pkg::SUM_W'(prod_sh24);
      endcase
      coord_new = sat_coord(coord_sum);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      div_cnt_in   = div_cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      tmp_in       = tmp_ff;
      mul_a        = '0;
      mul_b        = '0;
      mem_we       = 1'b0;
      mem_addr     = req_data.particle[lei_pkg::ADDR_W-1:0];
      mem_wdata    = '{x: req_data.load_x, y: req_data.load_y, z: req_data.load_z};
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         lei_pkg::ST_IDLE: begin
            if (req_accept && in_range) begin
               if (req_data.command == lei_pkg::CMD_LOAD) begin
                  mem_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{out_particle: req_data.particle,
                                   point_x: req_data.load_x,
                                   point_y: req_data.load_y,
                                   point_z: req_data.load_z,
                                   last: 1'b1};
               end else begin
                  idx_in = req_data.particle;
                  dvd_in = {ft_sat, 2'b00};
                  priority if (substeps_ff == '0)
                     n_in = lei_pkg::N_W'(1);
                  else if (int'(substeps_ff) > lei_pkg::MAX_SUBSTEPS)
                     n_in = lei_pkg::N_W'(lei_pkg::MAX_SUBSTEPS);
                  else
                     n_in = lei_pkg::N_W'(substeps_ff);
                  state_in = lei_pkg::ST_FETCH;
               end
            end
         end
         lei_pkg::ST_FETCH: begin
            x_in       = rd_vld_ff ? rd_ff.x : '0;
            y_in       = rd_vld_ff ? rd_ff.y : '0;
            z_in       = rd_vld_ff ? rd_ff.z : '0;
            rem_in     = '0;
            div_cnt_in = lei_pkg::DIV_CNT_W'(lei_pkg::DVD_W - 1);
            state_in   = lei_pkg::ST_DIV;
         end
         lei_pkg::ST_DIV: begin
            // restoring division, one quotient bit a cycle shifted into dvd
            if (rem_try >= {1'b0, n_ff}) begin
               rem_in = lei_pkg::N_W'(rem_try - {1'b0, n_ff});
               dvd_in = {dvd_ff[lei_pkg::DVD_W-2:0], 1'b1};
            end else begin
               rem_in = lei_pkg::N_W'(rem_try);
               dvd_in = {dvd_ff[lei_pkg::DVD_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               step_in  = lei_pkg::N_W'(1);
               state_in = lei_pkg::ST_M1;
            end
         end
         lei_pkg::ST_M1: begin
            mul_a = lei_pkg::MUL_A_W'(diff_yx);
            mul_b = $signed({1'b0, sigma_ff});
            // hold until the previous point has been taken
            if (!rsp_valid_ff || !rsp_stall) state_in = lei_pkg::ST_M2;
         end
         lei_pkg::ST_M2: begin
            rx_in    = lei_pkg::RATE_W'(prod_sh22);
            mul_a    = lei_pkg::MUL_A_W'(rho_s - z_ext);
            mul_b    = x_ff;
            state_in = lei_pkg::ST_M3;
         end
         lei_pkg::ST_M3: begin
            ry_in    = lei_pkg::RATE_W'(prod_sh22) - lei_pkg::RATE_W'(y_ff);
            mul_a    = lei_pkg::MUL_A_W'(x_ff);
            mul_b    = y_ff;
            state_in = lei_pkg::ST_M4;
         end
         lei_pkg::ST_M4: begin
            tmp_in   = lei_pkg::RATE_W'(prod_sh22);
            mul_a    = lei_pkg::MUL_A_W'(z_ff);
            mul_b    = $signed({1'b0, beta_ff});
            state_in = lei_pkg::ST_M5;
         end
         lei_pkg::ST_M5: begin
            rz_in    = tmp_ff - lei_pkg::RATE_W'(prod_sh22);
            mul_a    = sat_rate(rx_ff);
            mul_b    = $signed(lei_pkg::MUL_B_W'(dvd_ff));
            state_in = lei_pkg::ST_M6;
         end
         lei_pkg::ST_M6: begin
            nx_in    = coord_new;
            mul_a    = sat_rate(ry_ff);
            mul_b    = $signed(lei_pkg::MUL_B_W'(dvd_ff));
            state_in = lei_pkg::ST_M7;
         end
         lei_pkg::ST_M7: begin
            ny_in    = coord_new;
            mul_a    = sat_rate(rz_ff);
            mul_b    = $signed(lei_pkg::MUL_B_W'(dvd_ff));
            state_in = lei_pkg::ST_M8;
         end
         lei_pkg::ST_M8: begin
            x_in         = nx_ff;
            y_in         = ny_ff;
            z_in         = coord_new;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{out_particle: idx_ff, point_x: nx_ff, point_y: ny_ff,
                             point_z: coord_new, last: (step_ff == n_ff)};
            if (step_ff == n_ff) begin
               mem_we    = 1'b1;
               mem_addr  = idx_ff[lei_pkg::ADDR_W-1:0];
               mem_wdata = '{x: nx_ff, y: ny_ff, z: coord_new};
               state_in  = lei_pkg::ST_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = lei_pkg::ST_M1;
            end
         end
         default: state_in = lei_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lei_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         sigma_ff     <= lei_pkg::SIGMA_RESET;
         rho_ff       <= lei_pkg::RHO_RESET;
         beta_ff      <= lei_pkg::BETA_RESET;
         substeps_ff  <= lei_pkg::SUBSTEPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) vld_ff[mem_addr] <= 1'b1;
         if (csr_we) begin
            unique case (lei_pkg::csr_index_type'(csr_index))
               lei_pkg::CSR_SIGMA:    sigma_ff    <= csr_wdata;
               lei_pkg::CSR_RHO:      rho_ff      <= csr_wdata;
               lei_pkg::CSR_BETA:     beta_ff     <= csr_wdata;
               lei_pkg::CSR_SUBSTEPS: substeps_ff <= csr_wdata[lei_pkg::SUBSTEPS_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      div_cnt_ff  <= div_cnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rz_ff       <= rz_in;
      tmp_ff      <= tmp_in;
      prod_ff     <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) pos_mem[mem_addr] <= mem_wdata;
      rd_ff     <= pos_mem[req_data.particle[lei_pkg::ADDR_W-1:0]];
      rd_vld_ff <= vld_ff[req_data.particle[lei_pkg::ADDR_W-1:0]];
   end

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == lei_pkg::ST_IDLE || $past(state_ff) == lei_pkg::ST_M8))
      else $error("response raised outside load or final multiply step");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lei_pkg::ST_M8) |-> !rsp_valid_ff)
      else $error("point computed while the response register is still full");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lei_pkg::ST_IDLE && state_ff != lei_pkg::ST_FETCH &&
       state_ff != lei_pkg::ST_DIV) |-> (step_ff != '0 && step_ff <= n_ff))
      else $error("substep counter out of range");

   a_n_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lei_pkg::ST_FETCH) |->
         (n_ff != '0 && int'(n_ff) <= lei_pkg::MAX_SUBSTEPS))
      else $error("substep count not clamped");

endmodule
